/* src/coap_uri_pkg.sv */
// ----------------------------------------------------------------------------
// CoAP URI parser package
// Shared constants, types and helpers for the streaming URI host/port parser.
// ----------------------------------------------------------------------------
package coap_uri_pkg;

  localparam int unsigned MaxHostLen = 64;
  localparam int unsigned HostCntW   = $clog2(MaxHostLen);
  localparam int unsigned PortW      = 16;
  localparam int unsigned HostLenW   = 6;
  localparam int unsigned CharW      = 8;
  localparam int unsigned OutDataW   = 32;
  localparam int unsigned OutUserW   = 2;

  localparam logic [PortW-1:0] PortPlain  = 16'd5683;
  localparam logic [PortW-1:0] PortSecure = 16'd5684;
  localparam logic [PortW-1:0] PortMax    = 16'hFFFF;

  localparam logic [CharW-1:0] ChC      = 8'h63;
  localparam logic [CharW-1:0] ChO      = 8'h6F;
  localparam logic [CharW-1:0] ChA      = 8'h61;
  localparam logic [CharW-1:0] ChP      = 8'h70;
  localparam logic [CharW-1:0] ChS      = 8'h73;
  localparam logic [CharW-1:0] ChColon  = 8'h3A;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChLBrack = 8'h5B;
  localparam logic [CharW-1:0] ChRBrack = 8'h5D;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    PhScheme,
    PhHost,
    PhBracket,
    PhPort,
    PhStopped,
    PhFail
  } phase_e;

  typedef struct packed {
    logic [HostLenW-1:0] host_length;
    logic [PortW-1:0]    port;
    logic                secure;
    logic                uri_ok;
    logic [CharW-1:0]    host_char;
  } out_data_t;

  typedef struct packed {
    logic done_res;
    logic host_char_valid;
  } out_user_t;

  // Expected character of the fixed "coap" prefix at a given position.
  function automatic logic [CharW-1:0] scheme_char(input logic [1:0] pos);
    logic [CharW-1:0] ch;
    case (pos)
      2'd0:    ch = ChC;
      2'd1:    ch = ChO;
      2'd2:    ch = ChA;
      default: ch = ChP;
    endcase
    return ch;
  endfunction

endpackage

/* src/coap_uri_parser_unit.sv */
// ----------------------------------------------------------------------------
// CoAP URI parser unit
// Streaming parser that checks the coap:// or coaps:// scheme, echoes host
// characters and reports secure flag, port and host length at the URI end.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one URI character per item in s_axis_tdata, with
// s_axis_tlast marking the final character. For every accepted item the
// master stream delivers exactly one result item in the next cycle, from an
// output register. tuser flags whether the item carries a host character
// and whether it is the end-of-URI summary; summary fields are zero on
// other items, and host_char is zero when no character was appended.
// Throughput is one item per cycle while the master side does not stall:
// the parser state updates in a single short combinational pass per character.
// When the master side stalls, the result register holds its item and the
// slave side stops accepting until the result is taken; while the result
// is being taken, a new character is accepted in the same cycle.
// Reset empties the output register and puts the parser at the start of a
// scheme. After the final character of each URI the parser returns to
// that same state, ready for the next URI.
// ----------------------------------------------------------------------------
module coap_uri_parser_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [coap_uri_pkg::CharW-1:0]      s_axis_tdata,  // [7:0] char_code
  input  logic                                s_axis_tlast,  // last
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] host_char, [8] uri_ok, [9] secure, [25:10] port, [31:26] host_length
  output logic [coap_uri_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] host_char_valid, [1] done_res
  output logic [coap_uri_pkg::OutUserW-1:0]   m_axis_tuser
);

  localparam int unsigned AccW = coap_uri_pkg::PortW + 4;

  coap_uri_pkg::phase_e                    phase_q, phase_d;
  logic [2:0]                              scheme_pos_q, scheme_pos_d;
  logic                                    secure_q, secure_d;
  logic [coap_uri_pkg::PortW-1:0]          port_q, port_d;
  logic [coap_uri_pkg::HostCntW-1:0]       host_cnt_q, host_cnt_d;
  logic                                    ovf_q, ovf_d;

  logic                                    out_valid_q;
  coap_uri_pkg::out_data_t                 out_data_q, out_data_d;
  coap_uri_pkg::out_user_t                 out_user_q, out_user_d;

  logic                                    accept;
  logic [coap_uri_pkg::CharW-1:0]          ch;
  logic                                    host_take;
  logic [AccW-1:0]                         port_mac;
  logic                                    matched;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;

  assign port_mac = {1'b0, port_q, 3'b000} + {3'b000, port_q, 1'b0}
                  + AccW'(ch - coap_uri_pkg::ChZero);

  always_comb begin
    phase_d      = phase_q;
    scheme_pos_d = scheme_pos_q;
    secure_d     = secure_q;
    port_d       = port_q;
    host_cnt_d   = host_cnt_q;
    ovf_d        = ovf_q;
    host_take    = 1'b0;

    case (phase_q)
      coap_uri_pkg::PhScheme: begin
        if (scheme_pos_q < 3'd4) begin
          if (ch == coap_uri_pkg::scheme_char(scheme_pos_q[1:0])) begin
            scheme_pos_d = scheme_pos_q + 3'd1;
          end else begin
            phase_d = coap_uri_pkg::PhFail;
          end
        end else if (scheme_pos_q == 3'd4) begin
          if (ch == coap_uri_pkg::ChS && !secure_q) begin
            secure_d = 1'b1;
            port_d   = coap_uri_pkg::PortSecure;
          end else if (ch == coap_uri_pkg::ChColon) begin
            scheme_pos_d = 3'd5;
          end else begin
            phase_d = coap_uri_pkg::PhFail;
          end
        end else if (scheme_pos_q == 3'd5) begin
          if (ch == coap_uri_pkg::ChSlash) begin
            scheme_pos_d = 3'd6;
          end else begin
            phase_d = coap_uri_pkg::PhFail;
          end
        end else begin
          if (ch == coap_uri_pkg::ChSlash) begin
            phase_d = coap_uri_pkg::PhHost;
          end else begin
            phase_d = coap_uri_pkg::PhFail;
          end
        end
      end
      coap_uri_pkg::PhHost: begin
        if (ch == coap_uri_pkg::ChLBrack) begin
          phase_d = coap_uri_pkg::PhBracket;
        end else if (ch == coap_uri_pkg::ChColon) begin
          phase_d = coap_uri_pkg::PhPort;
          port_d  = '0;
        end else if (ch == coap_uri_pkg::ChSlash) begin
          phase_d = coap_uri_pkg::PhStopped;
        end else begin
          host_take = 1'b1;
        end
      end
      coap_uri_pkg::PhBracket: begin
        if (ch == coap_uri_pkg::ChRBrack) begin
          phase_d = coap_uri_pkg::PhHost;
        end else begin
          host_take = 1'b1;
        end
      end
      coap_uri_pkg::PhPort: begin
        if (ch == coap_uri_pkg::ChSlash) begin
          phase_d = coap_uri_pkg::PhStopped;
        end else if (ch inside {[coap_uri_pkg::ChZero:coap_uri_pkg::ChNine]}) begin
          if (port_mac > AccW'(coap_uri_pkg::PortMax)) begin
            port_d = coap_uri_pkg::PortMax;
            ovf_d  = 1'b1;
          end else begin
            port_d = port_mac[coap_uri_pkg::PortW-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    out_user_d.host_char_valid = 1'b0;
    out_data_d.host_char       = '0;
    if (host_take) begin
      if (host_cnt_q < coap_uri_pkg::HostCntW'(coap_uri_pkg::MaxHostLen - 1)) begin
        host_cnt_d                 = host_cnt_q + coap_uri_pkg::HostCntW'(1);
        out_user_d.host_char_valid = 1'b1;
        out_data_d.host_char       = ch;
      end else begin
        ovf_d = 1'b1;
      end
    end

    matched = (phase_d != coap_uri_pkg::PhScheme) && (phase_d != coap_uri_pkg::PhFail);

    out_user_d.done_res    = s_axis_tlast;
    out_data_d.uri_ok      = 1'b0;
    out_data_d.secure      = 1'b0;
    out_data_d.port        = '0;
    out_data_d.host_length = '0;
    if (s_axis_tlast) begin
      out_data_d.uri_ok      = matched && (host_cnt_d != '0) && (port_d != '0) && !ovf_d;
      out_data_d.secure      = secure_d;
      out_data_d.port        = port_d;
      out_data_d.host_length = coap_uri_pkg::HostLenW'(host_cnt_d);
      phase_d                = coap_uri_pkg::PhScheme;
      scheme_pos_d           = '0;
      secure_d               = 1'b0;
      port_d                 = coap_uri_pkg::PortPlain;
      host_cnt_d             = '0;
      ovf_d                  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= coap_uri_pkg::PhScheme;
      scheme_pos_q <= '0;
      secure_q     <= 1'b0;
      port_q       <= coap_uri_pkg::PortPlain;
      host_cnt_q   <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        scheme_pos_q <= scheme_pos_d;
        secure_q     <= secure_d;
        port_q       <= port_d;
        host_cnt_q   <= host_cnt_d;
        ovf_q        <= ovf_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* dv/tb_coap_uri_parser_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the CoAP URI parser unit
// Streams whole URIs one character per item into the parser and predicts,
// character by character, the echoed host bytes and the end-of-URI summary.
// A short directed set covers scheme errors, brackets, stops, port limits
// and host length limits. A random set follows, made mostly of well-formed
// URIs with random content and some noise and damaged URIs. Both stream
// sides idle in random bursts until the final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coap_uri_parser_unit;

  localparam int ItemTarget = 1350;
  localparam int StallLimit = 1000;

  typedef struct {
    bit        hv;
    bit [7:0]  hc;
    bit        done;
    bit        ok;
    bit        sec;
    bit [15:0] port;
    bit [5:0]  hlen;
  } uri_result_t;

  class uri_scoreboard;
    coap_uri_pkg::phase_e ph;
    int unsigned scheme_pos;
    int unsigned port_val;
    int unsigned host_cnt;
    bit          sec_flag;
    bit          ovf_flag;
    bit [7:0]    scheme_word [4];
    uri_result_t pending[$];
    int          mismatches;
    int          checked;
    int          summaries;
    int          usable;
    int          usable_secure;

    function new();
      scheme_word = '{coap_uri_pkg::ChC, coap_uri_pkg::ChO, coap_uri_pkg::ChA,
                      coap_uri_pkg::ChP};
      clear_state();
    endfunction

    function void clear_state();
      ph         = coap_uri_pkg::PhScheme;
      scheme_pos = 0;
      sec_flag   = 1'b0;
      port_val   = coap_uri_pkg::PortPlain;
      host_cnt   = 0;
      ovf_flag   = 1'b0;
    endfunction

    function void add_host(bit [7:0] c, inout uri_result_t r);
      if (host_cnt < coap_uri_pkg::MaxHostLen - 1) begin
        host_cnt++;
        r.hv = 1'b1;
        r.hc = c;
      end else begin
        ovf_flag = 1'b1;
      end
    endfunction

    function void scheme_step(bit [7:0] c);
      if (scheme_pos < 4) begin
        if (c == scheme_word[scheme_pos]) scheme_pos++;
        else ph = coap_uri_pkg::PhFail;
      end else if (scheme_pos == 4) begin
        if (c == coap_uri_pkg::ChS && !sec_flag) begin
          sec_flag = 1'b1;
          port_val = coap_uri_pkg::PortSecure;
        end else if (c == coap_uri_pkg::ChColon) begin
          scheme_pos = 5;
        end else begin
          ph = coap_uri_pkg::PhFail;
        end
      end else if (scheme_pos == 5) begin
        if (c == coap_uri_pkg::ChSlash) scheme_pos = 6;
        else ph = coap_uri_pkg::PhFail;
      end else begin
        if (c == coap_uri_pkg::ChSlash) ph = coap_uri_pkg::PhHost;
        else ph = coap_uri_pkg::PhFail;
      end
    endfunction

    function void note_char(bit [7:0] c, bit last);
      uri_result_t r;
      int unsigned v;
      r = '{default: 0};
      case (ph)
        coap_uri_pkg::PhScheme: scheme_step(c);
        coap_uri_pkg::PhHost: begin
          if (c == coap_uri_pkg::ChLBrack) begin
            ph = coap_uri_pkg::PhBracket;
          end else if (c == coap_uri_pkg::ChColon) begin
            ph = coap_uri_pkg::PhPort;
            port_val = 0;
          end else if (c == coap_uri_pkg::ChSlash) begin
            ph = coap_uri_pkg::PhStopped;
          end else begin
            add_host(c, r);
          end
        end
        coap_uri_pkg::PhBracket: begin
          if (c == coap_uri_pkg::ChRBrack) ph = coap_uri_pkg::PhHost;
          else add_host(c, r);
        end
        coap_uri_pkg::PhPort: begin
          if (c == coap_uri_pkg::ChSlash) begin
            ph = coap_uri_pkg::PhStopped;
          end else if (c >= coap_uri_pkg::ChZero && c <= coap_uri_pkg::ChNine) begin
            v = port_val * 10 + (c - coap_uri_pkg::ChZero);
            if (v > coap_uri_pkg::PortMax) begin
              v = coap_uri_pkg::PortMax;
              ovf_flag = 1'b1;
            end
            port_val = v;
          end
        end
        default: ;
      endcase
      if (last) begin
        r.done = 1'b1;
        r.ok   = ph != coap_uri_pkg::PhScheme && ph != coap_uri_pkg::PhFail &&
                 host_cnt > 0 && port_val > 0 && !ovf_flag;
        r.sec  = sec_flag;
        r.port = port_val[15:0];
        r.hlen = host_cnt[5:0];
        clear_state();
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("item %0d %s got 0x%0h expected 0x%0h",
                                  checked, name, got, want));
    endtask

    task check_result(logic [coap_uri_pkg::OutDataW-1:0] data,
                      logic [coap_uri_pkg::OutUserW-1:0] user);
      coap_uri_pkg::out_data_t d;
      coap_uri_pkg::out_user_t u;
      uri_result_t e;
      d = data;
      u = user;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("item %0d arrived with nothing expected", checked));
        return;
      end
      e = pending.pop_front();
      check_field("host_char_valid", 32'(u.host_char_valid), 32'(e.hv));
      check_field("host_char", 32'(d.host_char), 32'(e.hc));
      check_field("done_res", 32'(u.done_res), 32'(e.done));
      check_field("uri_ok", 32'(d.uri_ok), 32'(e.ok));
      check_field("secure", 32'(d.secure), 32'(e.sec));
      check_field("port", 32'(d.port), 32'(e.port));
      check_field("host_length", 32'(d.host_length), 32'(e.hlen));
      if (e.done) summaries++;
      if (e.ok) usable++;
      if (e.ok && e.sec) usable_secure++;
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [coap_uri_pkg::CharW-1:0]      s_axis_tdata = '0;
  logic                                s_axis_tlast = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [coap_uri_pkg::OutDataW-1:0]   m_axis_tdata;
  logic [coap_uri_pkg::OutUserW-1:0]   m_axis_tuser;

  uri_scoreboard sb = new();
  bit [7:0]      uri_bytes[$];
  int            uris_sent;
  int            chars_sent;
  int            idle_pct;
  int            sink_pct;
  int            stuck_cycles;

  coap_uri_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= StallLimit) begin
        $display("Watchdog: no item moved for %0d cycles.", stuck_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 30;
    endcase
  endfunction

  function automatic bit [7:0] rand_host_byte();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == coap_uri_pkg::ChLBrack || c == coap_uri_pkg::ChColon ||
           c == coap_uri_pkg::ChSlash);
    return c;
  endfunction

  task automatic push_char(bit [7:0] c, bit last);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i);
    while (!s_axis_tready);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_uri();
    for (int i = 0; i < uri_bytes.size(); i++) push_char(uri_bytes[i], i == uri_bytes.size() - 1);
    uris_sent++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) uri_bytes.push_back(s[i]);
  endtask

  task automatic run_text(string s);
    uri_bytes.delete();
    put_text(s);
    send_uri();
  endtask

  task automatic build_random_uri();
    int kind;
    int len;
    int cnt;
    int n;
    int sel;
    bit [7:0] c;
    uri_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) uri_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 1)) put_text("coaps://");
    else put_text("coap://");
    sel = $urandom_range(0, 99);
    if (sel < 4) len = 0;
    else if (sel < 92) len = $urandom_range(1, 16);
    else len = $urandom_range(55, 75);
    cnt = 0;
    while (cnt < len) begin
      if ($urandom_range(0, 15) == 0) begin
        uri_bytes.push_back(coap_uri_pkg::ChLBrack);
        n = $urandom_range(1, 5);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255));
          while (c == coap_uri_pkg::ChRBrack);
          uri_bytes.push_back(c);
        end
        uri_bytes.push_back(coap_uri_pkg::ChRBrack);
        cnt += n;
      end else begin
        uri_bytes.push_back(rand_host_byte());
        cnt++;
      end
    end
    if ($urandom_range(0, 99) < 60) begin
      uri_bytes.push_back(coap_uri_pkg::ChColon);
      sel = $urandom_range(0, 99);
      if (sel < 5) n = 0;
      else if (sel < 85) n = $urandom_range(1, 5);
      else n = $urandom_range(6, 7);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          do c = 8'($urandom_range(0, 255));
          while (c == coap_uri_pkg::ChSlash);
          uri_bytes.push_back(c);
        end
        uri_bytes.push_back(8'(coap_uri_pkg::ChZero + $urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 99) < 40) begin
      uri_bytes.push_back(coap_uri_pkg::ChSlash);
      repeat ($urandom_range(0, 8)) uri_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (kind < 14) begin
      n = $urandom_range(1, uri_bytes.size());
      while (uri_bytes.size() > n) void'(uri_bytes.pop_back());
    end else if (kind < 20) begin
      uri_bytes[$urandom_range(0, uri_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 15;
    sink_pct = 15;
    run_text("coap://a");
    run_text("coaps://b");
    run_text("coap://h:1");
    run_text("coap://h:65535");
    run_text("coap://h:65536");
    run_text("coap://h:4294967296");
    run_text("coap://h:");
    run_text("coap://h:0");
    run_text("coaps://[::1]:8x0/p");
    run_text("coap://[fe80");
    run_text("coap://ab/zz:9");
    run_text("coap:/");
    run_text("c");
    run_text("coapss://h");
    run_text("coAp://h");
    run_text("coaps:/x");
    run_text("coap://:5683");
    run_text("coap://");
    run_text("coap://h]a");
    run_text("coap://[a]b[c]");
    uri_bytes.delete();
    put_text("coap://");
    uri_bytes.push_back(8'h00);
    uri_bytes.push_back(8'hFF);
    uri_bytes.push_back(8'h80);
    uri_bytes.push_back(8'h7F);
    send_uri();
    uri_bytes.delete();
    put_text("coap://");
    repeat (coap_uri_pkg::MaxHostLen - 1) uri_bytes.push_back("x");
    send_uri();
    uri_bytes.delete();
    put_text("coaps://");
    repeat (coap_uri_pkg::MaxHostLen + 6) uri_bytes.push_back("y");
    put_text(":7");
    send_uri();

    while (chars_sent < ItemTarget) begin
      if (chars_sent > ItemTarget * 85 / 100) begin
        idle_pct = 0;
        sink_pct = 0;
      end else if (uris_sent % 8 == 0) begin
        idle_pct = pick_pct();
        sink_pct = pick_pct();
      end
      build_random_uri();
      send_uri();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Streamed %0d URIs as %0d characters; %0d result items compared.",
             uris_sent, chars_sent, sb.checked);
    $display("Of %0d URI summaries, %0d were usable and %0d of those used coaps.",
             sb.summaries, sb.usable, sb.usable_secure);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
